FILE: sv/rxrb_pkg.sv
// shared types, constants and codes for the receive ring buffer
package rxrb_pkg;

    // default store depth
    localparam int DEPTH_DEF = 64;

    // field widths fixed by the interface
    localparam int DATA_W     = 8;
    localparam int CNT_W      = 6;
    localparam int GAP_W      = 16;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [GAP_W-1:0] IDLE_GAP_RST   = 16'd200;
    localparam logic [CNT_W-1:0] READ_LIMIT_RST = 6'd20;

    // command codes
    localparam logic [CMD_W-1:0] CMD_BYTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_GAP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LIMIT = 2'd1;

    // drain sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_ADDR,
        S_RD_DATA,
        S_TERM
    } t_state;

    // one result transaction
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              is_terminator;
        logic [CNT_W-1:0]  byte_count;
        logic              last;
    } t_out_item;

endpackage

FILE: sv/rxrb_out_stage.sv
// single-entry output register that decouples the drain sequencer from the receiver
module rxrb_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  rxrb_pkg::t_out_item i_item,
    output logic               o_ready,
    output logic               o_valid,
    output rxrb_pkg::t_out_item o_item,
    input  logic               i_stall
);
    import rxrb_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // room when empty or when the held transaction leaves this cycle
    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    // payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_item <= i_item;
        end
    end

    // a held result never changes while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid && r_item == $past(r_item))
        else $error("output item changed while stalled");

    // a load is never refused silently while the register is free
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> o_ready)
        else $error("empty output register not ready");

    // a result taken with no new load leaves the register empty
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_stall && !i_load |=> !r_valid)
        else $error("taken result not removed");

endmodule

FILE: sv/rx_ring_buffer_idle_flush.sv
// receive ring buffer with idle flush: top level, store and drain sequencer
//
// Input channel (i_in_valid / o_in_stall) carries commands: a received byte, a
// read request or a one millisecond tick. Output channel (o_out_valid /
// i_out_stall) carries results. Config writes use i_cfg_valid / o_cfg_ready;
// index 0 is the idle gap in ms, index 1 the read limit. Write only when idle.
// Bytes and ticks are taken without stalling the input and give no result; a byte
// arriving after more than the idle gap of ticks empties the buffer first.
// When full the oldest byte is dropped, so at most DEPTH-1 bytes are held.
// A read drains up to read_limit bytes, oldest first, then a terminator
// transaction that carries the count and has last set.
// A read is accepted in S_IDLE; for each byte S_RD_ADDR issues a registered read
// of the store and S_RD_DATA loads it into the output register, then S_TERM loads
// the terminator. o_in_stall stays high until the terminator is loaded.
// A stalled receiver holds the output register and the sequencer waits.
// Reset clears pointers and idle counter and sets the registers to their reset values; the store is not cleared.
module rx_ring_buffer_idle_flush #(
    parameter int DEPTH = rxrb_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [rxrb_pkg::CMD_W-1:0]        i_cmd,
    input  logic [rxrb_pkg::DATA_W-1:0]       i_rx_byte,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rxrb_pkg::DATA_W-1:0]       o_data_byte,
    output logic                              o_is_terminator,
    output logic [rxrb_pkg::CNT_W-1:0]        o_byte_count,
    output logic                              o_last,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rxrb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rxrb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rxrb_pkg::*;

    localparam int              PTR_W    = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    // state
    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [GAP_W-1:0]   r_idle_cnt, n_idle_cnt;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [GAP_W-1:0]   r_idle_gap;
    logic [CNT_W-1:0]   r_read_limit;

    // store
    logic [DATA_W-1:0]  r_mem [DEPTH];
    logic [DATA_W-1:0]  r_rd_data;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic               rd_en;

    // output stage link
    logic               out_load;
    logic               out_ready;
    t_out_item          out_item;
    t_out_item          out_q;

    logic               in_acc;
    logic               flush;
    logic [PTR_W-1:0]   rd_base;
    logic [PTR_W-1:0]   wr_next;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_gap   <= IDLE_GAP_RST;
            r_read_limit <= READ_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_IDLE_GAP:   r_idle_gap   <= i_cfg_data;
                CFG_READ_LIMIT: r_read_limit <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // flush test and byte write pointers
    assign flush   = (r_idle_cnt > r_idle_gap);
    assign wr_addr = flush ? '0 : r_wr_ptr;
    assign rd_base = flush ? '0 : r_rd_ptr;
    assign wr_next = ptr_next(wr_addr);

    // sequencer next state and outputs
    always_comb begin
        n_state    = r_state;
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_idle_cnt = r_idle_cnt;
        n_count    = r_count;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        out_item   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_cmd)
                        CMD_TICK: begin
                            if (r_idle_cnt != '1) begin
                                n_idle_cnt = r_idle_cnt + 1'b1;
                            end
                        end
                        CMD_BYTE: begin
                            wr_en      = 1'b1;
                            n_idle_cnt = '0;
                            n_wr_ptr   = wr_next;
                            n_rd_ptr   = (rd_base == wr_next) ? ptr_next(rd_base) : rd_base;
                        end
                        CMD_READ: begin
                            n_count = '0;
                            n_state = S_RD_ADDR;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_ADDR: begin
                if (r_rd_ptr != r_wr_ptr && r_count < r_read_limit) begin
                    rd_en   = 1'b1;
                    n_state = S_RD_DATA;
                end else begin
                    n_state = S_TERM;
                end
            end
            S_RD_DATA: begin
                out_load           = 1'b1;
                out_item.data_byte = r_rd_data;
                if (out_ready) begin
                    n_rd_ptr = ptr_next(r_rd_ptr);
                    n_count  = r_count + 1'b1;
                    n_state  = S_RD_ADDR;
                end
            end
            S_TERM: begin
                out_load               = 1'b1;
                out_item.is_terminator = 1'b1;
                out_item.byte_count    = r_count;
                out_item.last          = 1'b1;
                if (out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_ptr   <= '0;
            r_wr_ptr   <= '0;
            r_idle_cnt <= '0;
            r_count    <= '0;
        end else begin
            r_state    <= n_state;
            r_rd_ptr   <= n_rd_ptr;
            r_wr_ptr   <= n_wr_ptr;
            r_idle_cnt <= n_idle_cnt;
            r_count    <= n_count;
        end
    end

    // byte store write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_rx_byte;
        end
    end

    // byte store read port, registered
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    // output register
    rxrb_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_item  (out_item),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .o_item  (out_q),
        .i_stall (i_out_stall)
    );

    assign o_data_byte     = out_q.data_byte;
    assign o_is_terminator = out_q.is_terminator;
    assign o_byte_count    = out_q.byte_count;
    assign o_last          = out_q.last;

    // pointers stay within the store
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_ptr <= LAST_PTR && r_wr_ptr <= LAST_PTR)
        else $error("pointer beyond store depth");

    // drain count never passes the read limit
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_count <= r_read_limit)
        else $error("drain count above read limit");

    // a store read is only issued when the buffer holds data
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD_DATA |-> r_rd_ptr != r_wr_ptr)
        else $error("read from empty buffer");

    // terminator count agrees with the limit in force
    a_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_terminator |-> o_byte_count <= r_read_limit && o_last)
        else $error("bad terminator transaction");

    // the store is never written while draining
    a_no_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_state == S_IDLE)
        else $error("store written during drain");

endmodule
